@@ design/busy_counter_utilisation_sampler_unit_defines.svh @@
// assertion macros for the busy counter utilisation sampler
// no dependencies
`ifndef BUSY_COUNTER_UTILISATION_SAMPLER_UNIT_DEFINES_SVH
`define BUSY_COUNTER_UTILISATION_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define BCUS_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCUS_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bcus_pkg.sv @@
// types and constants of the busy counter utilisation sampler
// no dependencies
package bcus_pkg;

    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [31:0] INTERVAL_RESET = 32'd500000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_T,
        ST_SUB_B,
        ST_CMP_I,
        ST_MUL_A,
        ST_MUL_B,
        ST_SEARCH,
        ST_FIN
    } state_t;

endpackage

@@ design/busy_counter_utilisation_sampler_unit.sv @@
// busy counter utilisation sampler: an input transfer steps through sub_t, sub_b and
// cmp_i; cached, first or invalid samples then go to fin, while a fresh computation
// passes mul_a, mul_b and the search (percent + 1 steps, 100 at the cap) before fin
// loads the result register; the next sample is taken the cycle after the result loads,
// once any result stall is over. one shared add/subtract unit of COUNT_WIDTH+8 bits forms
// the deltas, the interval compare, 200*delta and the threshold search.
`include "busy_counter_utilisation_sampler_unit_defines.svh"

module busy_counter_utilisation_sampler_unit #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [COUNT_WIDTH-1:0]       busy_ns,
    input  logic [COUNT_WIDTH-1:0]       now_ns,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [bcus_pkg::PCT_W-1:0]   percent,
    output logic                         from_cache
);

    localparam int EXT_W = COUNT_WIDTH + 8;

    bcus_pkg::state_t state_reg, state_next;

    logic [31:0]                interval_reg, interval_next;
    logic                       started_reg, started_next;
    logic                       available_reg, available_next;
    logic [bcus_pkg::PCT_W-1:0] cached_reg, cached_next;
    logic [COUNT_WIDTH-1:0]     prev_busy_reg, prev_busy_next;
    logic [COUNT_WIDTH-1:0]     prev_time_reg, prev_time_next;

    logic [COUNT_WIDTH-1:0]     busy_reg, busy_next;
    logic [COUNT_WIDTH-1:0]     now_reg, now_next;
    logic [COUNT_WIDTH-1:0]     elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0]     delta_reg, delta_next;
    logic [EXT_W-1:0]           acc_reg, acc_next;
    logic [bcus_pkg::PCT_W-1:0] c_reg, c_next;
    logic [bcus_pkg::PCT_W-1:0] best_reg, best_next;
    logic                       t_ge_reg, t_ge_next;
    logic                       t_gt_reg, t_gt_next;
    logic                       b_ge_reg, b_ge_next;

    logic                       res_ok_reg, res_ok_next;
    logic [bcus_pkg::PCT_W-1:0] res_pct_reg, res_pct_next;
    logic                       res_cache_reg, res_cache_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       ok_reg, ok_next;
    logic [bcus_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic                       cache_reg, cache_next;

    // shared add/subtract unit
    logic [EXT_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [EXT_W:0]   alu_sum;
    logic             alu_carry;

    logic in_xfer, out_free, search_stop;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != bcus_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign percent    = pct_reg;
    assign from_cache = cache_reg;

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            bcus_pkg::ST_SUB_T:
            begin
                alu_a = {8'b0, now_reg};
                alu_b = {8'b0, prev_time_reg};
            end
            bcus_pkg::ST_SUB_B:
            begin
                alu_a = {8'b0, busy_reg};
                alu_b = {8'b0, prev_busy_reg};
            end
            bcus_pkg::ST_CMP_I:
            begin
                alu_a = {8'b0, elapsed_reg};
                alu_b = {{(EXT_W-32){1'b0}}, interval_reg};
            end
            bcus_pkg::ST_MUL_A:
            begin
                alu_sub = 1'b0;
                alu_a   = {1'b0, delta_reg, 7'b0};
                alu_b   = {2'b0, delta_reg, 6'b0};
            end
            bcus_pkg::ST_MUL_B:
            begin
                alu_sub = 1'b0;
                alu_a   = acc_reg;
                alu_b   = {5'b0, delta_reg, 3'b0};
            end
            bcus_pkg::ST_SEARCH:
            begin
                alu_a = acc_reg;
                // odd multiples of elapsed: first step elapsed, then 2*elapsed
                alu_b = (c_reg == 7'd1) ? {8'b0, elapsed_reg} : {7'b0, elapsed_reg, 1'b0};
            end
            default:
            begin
                alu_sub = 1'b1;
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{EXT_W{1'b0}}, alu_sub};
    assign alu_carry = alu_sum[EXT_W];

    assign search_stop = !alu_carry || (c_reg == bcus_pkg::PCT_MAX);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcus_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = bcus_pkg::ST_SUB_T;
                end
            end
            bcus_pkg::ST_SUB_T:
            begin
                state_next = bcus_pkg::ST_SUB_B;
            end
            bcus_pkg::ST_SUB_B:
            begin
                state_next = bcus_pkg::ST_CMP_I;
            end
            bcus_pkg::ST_CMP_I:
            begin
                if (available_reg && t_ge_reg && !alu_carry)
                begin
                    state_next = bcus_pkg::ST_FIN;
                end
                else if (started_reg && t_gt_reg && b_ge_reg)
                begin
                    state_next = bcus_pkg::ST_MUL_A;
                end
                else
                begin
                    state_next = bcus_pkg::ST_FIN;
                end
            end
            bcus_pkg::ST_MUL_A:
            begin
                state_next = bcus_pkg::ST_MUL_B;
            end
            bcus_pkg::ST_MUL_B:
            begin
                state_next = bcus_pkg::ST_SEARCH;
            end
            bcus_pkg::ST_SEARCH:
            begin
                if (search_stop)
                begin
                    state_next = bcus_pkg::ST_FIN;
                end
            end
            bcus_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = bcus_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcus_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        interval_next  = interval_reg;
        started_next   = started_reg;
        available_next = available_reg;
        cached_next    = cached_reg;
        prev_busy_next = prev_busy_reg;
        prev_time_next = prev_time_reg;
        busy_next      = busy_reg;
        now_next       = now_reg;
        elapsed_next   = elapsed_reg;
        delta_next     = delta_reg;
        acc_next       = acc_reg;
        c_next         = c_reg;
        best_next      = best_reg;
        t_ge_next      = t_ge_reg;
        t_gt_next      = t_gt_reg;
        b_ge_next      = b_ge_reg;
        res_ok_next    = res_ok_reg;
        res_pct_next   = res_pct_reg;
        res_cache_next = res_cache_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        pct_next       = pct_reg;
        cache_next     = cache_reg;

        if (cfg_valid && cfg_ready)
        begin
            interval_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bcus_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    busy_next = busy_ns;
                    now_next  = now_ns;
                end
            end
            bcus_pkg::ST_SUB_T:
            begin
                elapsed_next = alu_sum[COUNT_WIDTH-1:0];
                t_ge_next    = alu_carry;
                t_gt_next    = alu_carry && (alu_sum[COUNT_WIDTH-1:0] != '0);
            end
            bcus_pkg::ST_SUB_B:
            begin
                delta_next = alu_sum[COUNT_WIDTH-1:0];
                b_ge_next  = alu_carry;
            end
            bcus_pkg::ST_CMP_I:
            begin
                if (available_reg && t_ge_reg && !alu_carry)
                begin
                    // inside the interval: cached value, no state change
                    res_ok_next    = 1'b1;
                    res_pct_next   = cached_reg;
                    res_cache_next = 1'b1;
                end
                else if (started_reg && t_gt_reg && b_ge_reg)
                begin
                    c_next    = 7'd1;
                    best_next = '0;
                end
                else
                begin
                    if (started_reg)
                    begin
                        available_next = 1'b0;
                        cached_next    = '0;
                    end
                    prev_busy_next = busy_reg;
                    prev_time_next = now_reg;
                    started_next   = 1'b1;
                    res_ok_next    = started_reg ? 1'b0 : available_reg;
                    res_pct_next   = (!started_reg && available_reg) ? cached_reg : '0;
                    res_cache_next = 1'b0;
                end
            end
            bcus_pkg::ST_MUL_A:
            begin
                acc_next = alu_sum[EXT_W-1:0];
            end
            bcus_pkg::ST_MUL_B:
            begin
                acc_next = alu_sum[EXT_W-1:0];
            end
            bcus_pkg::ST_SEARCH:
            begin
                if (alu_carry)
                begin
                    best_next = c_reg;
                    acc_next  = alu_sum[EXT_W-1:0];
                    c_next    = c_reg + 7'd1;
                end
                if (search_stop)
                begin
                    cached_next    = alu_carry ? c_reg : best_reg;
                    available_next = 1'b1;
                    prev_busy_next = busy_reg;
                    prev_time_next = now_reg;
                    res_ok_next    = 1'b1;
                    res_pct_next   = alu_carry ? c_reg : best_reg;
                    res_cache_next = 1'b0;
                end
            end
            bcus_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    pct_next       = res_pct_reg;
                    cache_next     = res_cache_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcus_pkg::ST_IDLE;
            interval_reg  <= bcus_pkg::INTERVAL_RESET;
            started_reg   <= 1'b0;
            available_reg <= 1'b0;
            cached_reg    <= '0;
            prev_busy_reg <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            interval_reg  <= interval_next;
            started_reg   <= started_next;
            available_reg <= available_next;
            cached_reg    <= cached_next;
            prev_busy_reg <= prev_busy_next;
            prev_time_reg <= prev_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_reg      <= busy_next;
        now_reg       <= now_next;
        elapsed_reg   <= elapsed_next;
        delta_reg     <= delta_next;
        acc_reg       <= acc_next;
        c_reg         <= c_next;
        best_reg      <= best_next;
        t_ge_reg      <= t_ge_next;
        t_gt_reg      <= t_gt_next;
        b_ge_reg      <= b_ge_next;
        res_ok_reg    <= res_ok_next;
        res_pct_reg   <= res_pct_next;
        res_cache_reg <= res_cache_next;
        ok_reg        <= ok_next;
        pct_reg       <= pct_next;
        cache_reg     <= cache_next;
    end

    `BCUS_ASSERT_NOW(a_not_ok_zero, clk, rst_n, out_valid && !ok,
        percent == '0 && !from_cache, "result without ok carries a value")
    `BCUS_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid,
        percent <= bcus_pkg::PCT_MAX, "percent above cap")
    `BCUS_ASSERT_NOW(a_search_step, clk, rst_n, state_reg == bcus_pkg::ST_SEARCH,
        c_reg >= 7'd1 && c_reg <= bcus_pkg::PCT_MAX, "search step out of range")
    `BCUS_ASSERT_NEXT(a_fin_load, clk, rst_n, state_reg == bcus_pkg::ST_FIN && out_free,
        out_valid && ok == $past(res_ok_reg), "finished result not loaded")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for busy_counter_utilisation_sampler_unit: directed table, then
// random sample streams checked against an in-file utilisation predictor
// depends on bcus_pkg and the sampler rtl
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SCRIPT_ROWS = 22;
    localparam int GROUP_ITEMS = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                       ok;
        logic [bcus_pkg::PCT_W-1:0] percent;
        logic                       from_cache;
    } util_result_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_INTERVAL
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [31:0]  interval;
        logic [63:0]  busy;
        logic [63:0]  now;
        logic         typed;
        util_result_t want;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{ROW_SAMPLE,   32'd0, 64'd0,          64'd0,          1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd0,          64'd0,          1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1000,       64'd1000,       1'b1, '{1'b1, 7'd100, 1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1500,       64'd1500,       1'b1, '{1'b1, 7'd100, 1'b1}},
        '{ROW_SAMPLE,   32'd0, 64'd1000,       64'd500001000,  1'b1, '{1'b1, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1000,       64'd1000000999, 1'b1, '{1'b1, 7'd0,   1'b1}},
        '{ROW_SAMPLE,   32'd0, 64'd999,        64'd2000000000, 1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd500000999,  64'd3000000000, 1'b1, '{1'b1, 7'd50,  1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1005000999, 64'd4000000000, 1'b0, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1510000998, 64'd5000000000, 1'b0, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd1510000998, 64'd4999999999, 1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, '1,             '1,             1'b0, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, '1,             64'd0,          1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd0,          '1,             1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_INTERVAL, 32'd0, 64'd0,          64'd0,          1'b0, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd5,          64'd10,         1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd105,        64'd210,        1'b1, '{1'b1, 7'd50,  1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd105,        64'd210,        1'b1, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd205,        64'd410,        1'b1, '{1'b1, 7'd50,  1'b0}},
        '{ROW_INTERVAL, '1,    64'd0,          64'd0,          1'b0, '{1'b0, 7'd0,   1'b0}},
        '{ROW_SAMPLE,   32'd0, 64'd206,        64'd4294967704, 1'b1, '{1'b1, 7'd50,  1'b1}},
        '{ROW_SAMPLE,   32'd0, 64'd207,        64'd4294967705, 1'b0, '{1'b0, 7'd0,   1'b0}}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [31:0]                cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [63:0]                busy_ns = '0;
    logic [63:0]                now_ns = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       ok;
    logic [bcus_pkg::PCT_W-1:0] percent;
    logic                       from_cache;

    // predictor state
    logic [31:0]                interval_setting = bcus_pkg::INTERVAL_RESET;
    logic                       have_sample = 1'b0;
    logic                       have_rate = 1'b0;
    logic [bcus_pkg::PCT_W-1:0] rate_pct = '0;
    logic [63:0]                last_busy = '0;
    logic [63:0]                last_time = '0;

    util_result_t     awaited[$];
    util_result_t     oldest;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               sample_idle_pct = 0;
    int               result_stall_pct = 0;
    int               hold_requests = 0;

    int               row;
    int               phase_idx;
    int               group;
    int               k;
    int               pick;
    logic [31:0]      new_interval;
    logic [63:0]      gen_busy;
    logic [63:0]      gen_now;
    logic [63:0]      advance;
    logic [63:0]      busy_gain;
    logic [79:0]      wide;

    busy_counter_utilisation_sampler_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .busy_ns    (busy_ns),
        .now_ns     (now_ns),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .percent    (percent),
        .from_cache (from_cache)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic util_result_t predict_utilisation(input logic [63:0] b,
                                                         input logic [63:0] n);
        util_result_t               r;
        logic [79:0]                lhs;
        logic [79:0]                rhs;
        logic [bcus_pkg::PCT_W-1:0] pct;
        r = '0;
        if (have_rate && n >= last_time && (n - last_time) < {32'b0, interval_setting})
        begin
            r.ok = 1'b1;
            r.percent = rate_pct;
            r.from_cache = 1'b1;
            return r;
        end
        if (have_sample)
        begin
            if (n > last_time && b >= last_busy)
            begin
                // largest c with 200*delta >= elapsed*(2c-1)
                lhs = 80'(b - last_busy) * 80'd200;
                pct = '0;
                for (int c = 1; c <= int'(bcus_pkg::PCT_MAX); c++)
                begin
                    rhs = 80'(n - last_time) * 80'(2 * c - 1);
                    if (lhs >= rhs)
                        pct = c[bcus_pkg::PCT_W-1:0];
                end
                rate_pct = pct;
                have_rate = 1'b1;
            end
            else
            begin
                have_rate = 1'b0;
                rate_pct = '0;
            end
        end
        last_busy = b;
        last_time = n;
        have_sample = 1'b1;
        r.ok = have_rate;
        r.percent = have_rate ? rate_pct : '0;
        r.from_cache = 1'b0;
        return r;
    endfunction

    task automatic send_sample(input logic [63:0] b, input logic [63:0] n, input logic typed,
                               input util_result_t want);
        util_result_t expected;
        while (sample_idle_pct != 0 && $urandom_range(0, 99) < sample_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        busy_ns <= b;
        now_ns <= n;
        do @(posedge clk); while (in_stall);
        expected = predict_utilisation(b, n);
        if (typed)
            expected = want;
        awaited.push_back(expected);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_interval(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        interval_setting = value;
    endtask

    // result side: random stall plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= (result_stall_pct != 0) && ($urandom_range(0, 99) < result_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: ok=%0d percent=%0d from_cache=%0d",
                             ok, percent, from_cache);
            end
            else
            begin
                oldest = awaited.pop_front();
                if (ok !== oldest.ok || percent !== oldest.percent
                    || from_cache !== oldest.from_cache)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp ok=%0d pct=%0d fc=%0d got ok=%0d pct=%0d fc=%0d",
                                 oldest.ok, oldest.percent, oldest.from_cache,
                                 ok, percent, from_cache);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < SCRIPT_ROWS; row++)
        begin
            if (SCRIPT[row].kind == ROW_INTERVAL)
            begin
                wait_idle();
                write_interval(SCRIPT[row].interval);
            end
            else
                send_sample(SCRIPT[row].busy, SCRIPT[row].now, SCRIPT[row].typed,
                            SCRIPT[row].want);
        end

        gen_busy = '0;
        gen_now = '0;
        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    sample_idle_pct = 0;
                    result_stall_pct <= 0;
                end
                1:
                begin
                    sample_idle_pct = 74;
                    result_stall_pct <= 0;
                end
                2:
                begin
                    sample_idle_pct = 0;
                    result_stall_pct <= 74;
                end
                default:
                begin
                    sample_idle_pct = 26;
                    result_stall_pct <= 26;
                end
            endcase
            for (group = 0; group < 4; group++)
            begin
                wait_idle();
                case ($urandom_range(0, 5))
                    0: new_interval = '0;
                    1: new_interval = '1;
                    2: new_interval = 32'd1;
                    3: new_interval = $urandom_range(2, 1000);
                    default: new_interval = $urandom_range(1000, 2000000);
                endcase
                write_interval(new_interval);
                if (phase_idx == 0 && group == 1)
                    hold_requests <= hold_requests + 1;
                for (k = 0; k < GROUP_ITEMS; k++)
                begin
                    case ($urandom_range(0, 9))
                        0: advance = $urandom_range(1, 3);
                        1: advance = (interval_setting > 1) ? interval_setting - 1 : 64'd1;
                        2: advance = (interval_setting != 0) ? interval_setting : 64'd1;
                        3, 4: advance = (interval_setting > 1)
                                        ? $urandom_range(interval_setting - 1, 1) : 64'd1;
                        5, 6, 7: advance = interval_setting + $urandom_range(0, 1 << 20);
                        8: advance = $urandom_range(1, 2000);
                        default: advance = {$urandom_range(0, 3), $urandom};
                    endcase
                    case ($urandom_range(0, 3))
                        0, 1:
                        begin
                            // land on or just below a rounding threshold
                            wide = (80'(advance) * 80'(2 * $urandom_range(1, 100) - 1) + 80'd199)
                                   / 80'd200;
                            busy_gain = wide[63:0];
                            if (busy_gain != 0 && $urandom_range(0, 1) == 1)
                                busy_gain = busy_gain - 1;
                        end
                        2:
                        begin
                            wide = 80'(advance) * 80'($urandom_range(0, 130)) / 80'd100;
                            busy_gain = wide[63:0];
                        end
                        default: busy_gain = $urandom_range(0, 3);
                    endcase
                    pick = $urandom_range(0, 99);
                    if (pick < 80)
                    begin
                        gen_now = gen_now + advance;
                        gen_busy = gen_busy + busy_gain;
                    end
                    else if (pick < 88)
                    begin
                        gen_now = gen_now - $urandom_range(0, 1000);
                        gen_busy = gen_busy + busy_gain;
                    end
                    else if (pick < 94)
                    begin
                        gen_now = gen_now + advance;
                        gen_busy = gen_busy - $urandom_range(1, 1000);
                    end
                    else
                    begin
                        gen_now = {$urandom, $urandom};
                        gen_busy = {$urandom, $urandom};
                    end
                    send_sample(gen_busy, gen_now, 1'b0, '0);
                end
            end
        end

        wait_idle();
        repeat (120) @(posedge clk);
        if (mismatch_count == 0 && awaited.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
